@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and muted in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent at the same edge
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mas_pkg.sv @@
// ----------------------------------------------------------------------------
// mas_pkg
// types and codes shared by the macro argument splitter modules
// ----------------------------------------------------------------------------
package mas_pkg;

    // default sizing
    localparam int DEF_STACK_DEPTH = 32;
    localparam int DEF_MAX_TOKENS  = 4096;
    localparam int DEF_MAX_ARGS    = 256;
    localparam int QUEUE_DEPTH     = 2;

    // output field widths
    localparam int STATUS_W   = 4;
    localparam int NUM_W      = 8;
    localparam int LEN_W      = 12;
    localparam int CONSUMED_W = 13;

    // token classes
    localparam logic [3:0] C_OTHER = 4'd0;
    localparam logic [3:0] C_LPAR  = 4'd1;
    localparam logic [3:0] C_RPAR  = 4'd2;
    localparam logic [3:0] C_LBRK  = 4'd3;
    localparam logic [3:0] C_RBRK  = 4'd4;
    localparam logic [3:0] C_LBRC  = 4'd5;
    localparam logic [3:0] C_RBRC  = 4'd6;
    localparam logic [3:0] C_LBIN  = 4'd7;
    localparam logic [3:0] C_RBIN  = 4'd8;
    localparam logic [3:0] C_BLOCK = 4'd9;
    localparam logic [3:0] C_END   = 4'd10;
    localparam logic [3:0] C_FUN   = 4'd11;
    localparam logic [3:0] C_ARROW = 4'd12;
    localparam logic [3:0] C_WHEN  = 4'd13;
    localparam logic [3:0] C_COMMA = 4'd14;
    localparam logic [3:0] C_VAR   = 4'd15;

    // expected closer codes
    localparam logic [2:0] K_RPAR = 3'd0;
    localparam logic [2:0] K_RBRK = 3'd1;
    localparam logic [2:0] K_RBRC = 3'd2;
    localparam logic [2:0] K_RBIN = 3'd3;
    localparam logic [2:0] K_END  = 3'd4;
    localparam logic [2:0] K_FUN  = 3'd5;
    localparam logic [2:0] K_NONE = 3'd7;

    // result status
    localparam logic [3:0] ST_NO_CALL   = 4'd0;
    localparam logic [3:0] ST_OPENED    = 4'd1;
    localparam logic [3:0] ST_IN_ARG    = 4'd2;
    localparam logic [3:0] ST_ARG_END   = 4'd3;
    localparam logic [3:0] ST_CALL_END  = 4'd4;
    localparam logic [3:0] ST_EMPTY_ARG = 4'd5;
    localparam logic [3:0] ST_UNTERM    = 4'd6;
    localparam logic [3:0] ST_OVERFLOW  = 4'd7;
    localparam logic [3:0] ST_IGNORED   = 4'd8;

    typedef struct packed {
        logic       start_of_call;
        logic [3:0] token_class;
        logic [3:0] next_class;
        logic [3:0] after_next_class;
        logic       end_of_input;
    } mas_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [NUM_W-1:0]      argument_number;
        logic [LEN_W-1:0]      argument_length;
        logic [CONSUMED_W-1:0] consumed_count;
    } mas_out_t;

    // token after classification
    typedef struct packed {
        logic       start;
        logic       last;
        logic       lpar;
        logic       rpar;
        logic       comma;
        logic       arrow_when;
        logic       plain;
        logic [2:0] opens;
        logic [2:0] closes;
        logic [2:0] fun_push;
    } mas_cls_t;

endpackage

@@ rtl/core/macro_argument_splitter.sv @@
// ----------------------------------------------------------------------------
// macro_argument_splitter
// splits the argument list of a macro call at top-level commas and ")"
// ----------------------------------------------------------------------------
// Input side is a queue: drive in_data and push, a word is taken at an edge
// with push high and full low. Each word is one pre-classified token with two
// lookahead classes. Result side is a queue too: while empty is low, out_data
// holds the oldest status word, taken at an edge with pop high.
// Every token word gives exactly one status word, in order.
// A taken word waits in the front queue; its status word then goes into the
// result queue, which out_data shows. Throughput: one token per cycle while the
// result queue has room, set by the closer stack update in the back end; the
// stack is a shift stack: one or two pops, a push or a top rewrite are one step.
// Two-word queues sit between front and back and on the result side, so
// when pop is held low the block keeps taking words until both fill, then
// raises full; nothing is lost or repeated.
// Reset empties both queues and leaves the splitter idle with no call open;
// the stack contents are not cleared, only entries below the pointer are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module macro_argument_splitter #(
    parameter int STACK_DEPTH = mas_pkg::DEF_STACK_DEPTH,
    parameter int MAX_TOKENS  = mas_pkg::DEF_MAX_TOKENS,
    parameter int MAX_ARGS    = mas_pkg::DEF_MAX_ARGS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mas_pkg::mas_in_t  in_data,
    output logic              empty,
    input  logic              pop,
    output mas_pkg::mas_out_t out_data
);
    import mas_pkg::*;

    mas_cls_t                    mid_head;
    logic                        mid_empty, mid_take;
    mas_out_t                    res_data;
    logic                        res_valid, out_full;
    logic [$bits(mas_out_t)-1:0] out_vec;

    mas_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_data (in_data),
        .take    (mid_take),
        .head    (mid_head),
        .empty   (mid_empty)
    );

    mas_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_TOKENS  (MAX_TOKENS),
        .MAX_ARGS    (MAX_ARGS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_empty (mid_empty),
        .src_data  (mid_head),
        .src_take  (mid_take),
        .dst_full  (out_full),
        .dst_push  (res_valid),
        .dst_data  (res_data)
    );

    mas_queue #(
        .WIDTH ($bits(mas_out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_data),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_vec),
        .empty   (empty)
    );

    assign out_data = mas_out_t'(out_vec);

    `ASSERT_ALWAYS(a_no_out_overrun, !(res_valid && out_full), "result written into full queue")
    `ASSERT_NEXT(a_accept_lands, push && !full, !mid_empty, "accepted word missing from front queue")
    `ASSERT_NEXT(a_result_lands, res_valid, !empty, "result word missing from output queue")
    `ASSERT_SAME(a_consumed_only_at_end,
                 !empty && (out_data.status != ST_CALL_END),
                 out_data.consumed_count == '0,
                 "consumed count outside call end")

endmodule

@@ rtl/core/mas_queue.sv @@
// ----------------------------------------------------------------------------
// mas_queue
// small first-in first-out buffer of words with full and empty flags
// ----------------------------------------------------------------------------
module mas_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = mas_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import mas_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/mas_front.sv @@
// ----------------------------------------------------------------------------
// mas_front
// accepts token words, decodes opener, closer and fun lookahead, and queues them
// ----------------------------------------------------------------------------
module mas_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mas_pkg::mas_in_t   in_data,
    input  logic               take,
    output mas_pkg::mas_cls_t  head,
    output logic               empty
);
    import mas_pkg::*;

    mas_cls_t                 cls;
    logic [$bits(mas_cls_t)-1:0] head_vec;

    function automatic logic [2:0] opens_code(input logic [3:0] tc);
        case (tc)
            C_LPAR:  opens_code = K_RPAR;
            C_LBRK:  opens_code = K_RBRK;
            C_LBRC:  opens_code = K_RBRC;
            C_LBIN:  opens_code = K_RBIN;
            C_BLOCK: opens_code = K_END;
            default: opens_code = K_NONE;
        endcase
    endfunction

    function automatic logic [2:0] closes_code(input logic [3:0] tc);
        case (tc)
            C_RPAR:  closes_code = K_RPAR;
            C_RBRK:  closes_code = K_RBRK;
            C_RBRC:  closes_code = K_RBRC;
            C_RBIN:  closes_code = K_RBIN;
            C_END:   closes_code = K_END;
            C_FUN:   closes_code = K_FUN;
            default: closes_code = K_NONE;
        endcase
    endfunction

    always_comb
    begin
        cls.start      = in_data.start_of_call;
        cls.last       = in_data.end_of_input;
        cls.lpar       = (in_data.token_class == C_LPAR);
        cls.rpar       = (in_data.token_class == C_RPAR);
        cls.comma      = (in_data.token_class == C_COMMA);
        cls.arrow_when = (in_data.token_class == C_ARROW) || (in_data.token_class == C_WHEN);
        cls.plain      = (in_data.token_class == C_OTHER) || (in_data.token_class == C_VAR);
        cls.opens      = opens_code(in_data.token_class);
        cls.closes     = closes_code(in_data.token_class);
        cls.fun_push   = K_NONE;
        // fun( gets the unresolved sentinel, fun Name( is a named fun closed by end
        if (in_data.token_class == C_FUN)
        begin
            if (in_data.next_class == C_LPAR)
            begin
                cls.fun_push = K_FUN;
            end
            else if ((in_data.next_class == C_VAR) && (in_data.after_next_class == C_LPAR))
            begin
                cls.fun_push = K_END;
            end
        end
    end

    mas_queue #(
        .WIDTH ($bits(mas_cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (take),
        .rd_data (head_vec),
        .empty   (empty)
    );

    assign head = mas_cls_t'(head_vec);

endmodule

@@ rtl/core/mas_back.sv @@
// ----------------------------------------------------------------------------
// mas_back
// closer stack and argument counters, one classified token word per cycle while the result side has room
// ----------------------------------------------------------------------------
module mas_back #(
    parameter int STACK_DEPTH = mas_pkg::DEF_STACK_DEPTH,
    parameter int MAX_TOKENS  = mas_pkg::DEF_MAX_TOKENS,
    parameter int MAX_ARGS    = mas_pkg::DEF_MAX_ARGS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_empty,
    input  mas_pkg::mas_cls_t  src_data,
    output logic               src_take,
    input  logic               dst_full,
    output logic               dst_push,
    output mas_pkg::mas_out_t  dst_data
);
    import mas_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int POS_W = $clog2(MAX_TOKENS + 1);
    localparam int CL_W  = $clog2(MAX_TOKENS);
    localparam int ARG_W = $clog2(MAX_ARGS);

    localparam logic [2:0] OP_HOLD    = 3'd0;
    localparam logic [2:0] OP_PUSH    = 3'd1;
    localparam logic [2:0] OP_POP1    = 3'd2;
    localparam logic [2:0] OP_POP2    = 3'd3;
    localparam logic [2:0] OP_SET_END = 3'd4;

    logic [2:0]       stk_reg  [STACK_DEPTH];
    logic [2:0]       stk_next [STACK_DEPTH];
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [ARG_W-1:0] args_reg, args_next;
    logic [CL_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             call_reg, call_next;

    logic [2:0]       top, top_b, push_code;
    logic             fun_pop, fun_end, boundary, nest_pop, push_want, push_ovf;
    logic [SP_W-1:0]  sp_b, sp_after;
    logic [2:0]       op_raw, stk_op;
    mas_out_t         res;

    assign src_take = !src_empty && !dst_full;
    assign dst_push = src_take;
    assign dst_data = res;

    // top of stack, with the fun sentinel resolved first
    assign top       = (sp_reg == '0) ? K_NONE : stk_reg[0];
    assign fun_pop   = (top == K_FUN) && (src_data.comma || src_data.rpar);
    assign fun_end   = (top == K_FUN) && src_data.arrow_when;
    assign sp_b      = fun_pop ? sp_reg - 1'b1 : sp_reg;
    assign top_b     = fun_pop ? ((sp_reg > SP_W'(1)) ? stk_reg[1] : K_NONE)
                     : (fun_end ? K_END : top);
    assign boundary  = (sp_b == '0) && (src_data.comma || src_data.rpar);
    assign nest_pop  = !src_data.plain && (top_b != K_NONE) && (src_data.closes == top_b);
    assign push_want = !src_data.plain && !nest_pop
                     && ((src_data.opens != K_NONE) || (src_data.fun_push != K_NONE));
    assign push_code = (src_data.opens != K_NONE) ? src_data.opens : src_data.fun_push;
    assign push_ovf  = push_want && (sp_b == SP_W'(STACK_DEPTH));

    always_comb
    begin
        op_raw   = OP_HOLD;
        sp_after = sp_reg;
        if (fun_pop && !boundary && nest_pop)
        begin
            op_raw   = OP_POP2;
            sp_after = sp_reg - SP_W'(2);
        end
        else if (fun_pop)
        begin
            op_raw   = OP_POP1;
            sp_after = sp_b;
        end
        else if (fun_end)
        begin
            op_raw = OP_SET_END;
        end
        else if (!boundary && nest_pop)
        begin
            op_raw   = OP_POP1;
            sp_after = sp_reg - 1'b1;
        end
        else if (!boundary && push_want && !push_ovf)
        begin
            op_raw   = OP_PUSH;
            sp_after = sp_reg + 1'b1;
        end
    end

    // shift stack: entry 0 is the top, each entry reads only itself, the entry above and the two below
    for (genvar g = 0; g < STACK_DEPTH; g++)
    begin : g_stk
        logic [2:0] from_above, from_below1, from_below2, set_end_val;
        if (g == 0)
        begin : g_top
            assign from_above  = push_code;
            assign set_end_val = K_END;
        end
        else
        begin : g_mid
            assign from_above  = stk_reg[g-1];
            assign set_end_val = stk_reg[g];
        end
        if (g + 1 < STACK_DEPTH)
        begin : g_b1
            assign from_below1 = stk_reg[g+1];
        end
        else
        begin : g_b1_edge
            assign from_below1 = stk_reg[g];
        end
        if (g + 2 < STACK_DEPTH)
        begin : g_b2
            assign from_below2 = stk_reg[g+2];
        end
        else
        begin : g_b2_edge
            assign from_below2 = stk_reg[g];
        end
        always_comb
        begin
            case (stk_op)
                OP_PUSH:    stk_next[g] = from_above;
                OP_POP1:    stk_next[g] = from_below1;
                OP_POP2:    stk_next[g] = from_below2;
                OP_SET_END: stk_next[g] = set_end_val;
                default:    stk_next[g] = stk_reg[g];
            endcase
        end
    end

    always_comb
    begin
        sp_next   = sp_reg;
        args_next = args_reg;
        len_next  = len_reg;
        pos_next  = pos_reg;
        call_next = call_reg;
        stk_op    = OP_HOLD;
        res       = '0;
        if (src_data.start)
        begin
            call_next = src_data.lpar;
            if (src_data.lpar)
            begin
                sp_next    = '0;
                args_next  = '0;
                len_next   = '0;
                pos_next   = POS_W'(1);
                res.status = ST_OPENED;
            end
            else
            begin
                res.status = ST_NO_CALL;
            end
        end
        else if (!call_reg)
        begin
            res.status = ST_IGNORED;
        end
        else if (pos_reg == POS_W'(MAX_TOKENS))
        begin
            res.status          = ST_OVERFLOW;
            res.argument_number = NUM_W'(args_reg);
            res.argument_length = LEN_W'(len_reg);
            call_next           = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            if (!boundary)
            begin
                if (push_ovf)
                begin
                    res.status          = ST_OVERFLOW;
                    res.argument_number = NUM_W'(args_reg);
                    res.argument_length = LEN_W'(len_reg);
                    call_next           = 1'b0;
                end
                else
                begin
                    stk_op              = op_raw;
                    sp_next             = sp_after;
                    len_next            = len_reg + 1'b1;
                    res.status          = ST_IN_ARG;
                    res.argument_number = NUM_W'(args_reg);
                    res.argument_length = LEN_W'(len_next);
                end
            end
            else
            begin
                stk_op  = op_raw;
                sp_next = sp_after;
                if ((len_reg == '0) && ((args_reg != '0) || src_data.comma))
                begin
                    res.status          = ST_EMPTY_ARG;
                    res.argument_number = NUM_W'(args_reg);
                    call_next           = 1'b0;
                end
                else if (src_data.rpar)
                begin
                    res.status          = ST_CALL_END;
                    res.argument_number = NUM_W'(args_reg);
                    res.argument_length = LEN_W'(len_reg);
                    res.consumed_count  = CONSUMED_W'(pos_next);
                    call_next           = 1'b0;
                end
                else if (args_reg == ARG_W'(MAX_ARGS - 1))
                begin
                    res.status          = ST_OVERFLOW;
                    res.argument_number = NUM_W'(args_reg);
                    res.argument_length = LEN_W'(len_reg);
                    call_next           = 1'b0;
                end
                else
                begin
                    res.status          = ST_ARG_END;
                    res.argument_number = NUM_W'(args_reg);
                    res.argument_length = LEN_W'(len_reg);
                    args_next           = args_reg + 1'b1;
                    len_next            = '0;
                end
            end
        end
        // input ran out with the call still open
        if (call_next && src_data.last)
        begin
            res.status          = ST_UNTERM;
            res.argument_number = NUM_W'(args_next);
            res.argument_length = LEN_W'(len_next);
            res.consumed_count  = '0;
            call_next           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            args_reg <= '0;
            len_reg  <= '0;
            pos_reg  <= '0;
            call_reg <= 1'b0;
        end
        else if (src_take)
        begin
            sp_reg   <= sp_next;
            args_reg <= args_next;
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            call_reg <= call_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            stk_reg <= stk_next;
        end
    end

endmodule

@@ verif/macro_argument_splitter_checker.sv @@
// ----------------------------------------------------------------------------
// macro_argument_splitter_checker
// watches both queue sides of the splitter, predicts one status word per
// token word taken and compares each status word popped against the oldest
// prediction, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module macro_argument_splitter_checker #(
    parameter int STACK_DEPTH = mas_pkg::DEF_STACK_DEPTH,
    parameter int MAX_TOKENS  = mas_pkg::DEF_MAX_TOKENS,
    parameter int MAX_ARGS    = mas_pkg::DEF_MAX_ARGS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  mas_pkg::mas_in_t  in_data,
    input  logic              empty,
    input  logic              pop,
    input  mas_pkg::mas_out_t out_data,
    output int                fail_count,
    output int                outstanding,
    output int                words_checked,
    output logic [15:0]       status_seen
);

    import mas_pkg::*;

    // shadow of the splitter state
    logic [2:0] closer_stack [STACK_DEPTH];
    int         open_count = 0;
    int         args_done  = 0;
    int         arg_length = 0;
    int         token_pos  = 0;
    bit         in_call    = 1'b0;

    mas_out_t   predicted_status [$];

    function automatic logic [2:0] closer_code(logic [3:0] cls);
        case (cls)
            C_RPAR:  return K_RPAR;
            C_RBRK:  return K_RBRK;
            C_RBRC:  return K_RBRC;
            C_RBIN:  return K_RBIN;
            C_END:   return K_END;
            C_FUN:   return K_FUN;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [2:0] opener_code(logic [3:0] cls);
        case (cls)
            C_LPAR:  return K_RPAR;
            C_LBRK:  return K_RBRK;
            C_LBRC:  return K_RBRC;
            C_LBIN:  return K_RBIN;
            C_BLOCK: return K_END;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [2:0] stack_top();
        if (open_count == 0 || open_count > STACK_DEPTH)
            return K_NONE;
        return closer_stack[open_count - 1];
    endfunction

    function automatic bit push_closer(logic [2:0] code);
        if (open_count >= STACK_DEPTH)
            return 1'b0;
        closer_stack[open_count] = code;
        open_count++;
        return 1'b1;
    endfunction

    // resolves a fun sentinel on top, then tells whether cls splits the list
    function automatic bit at_separator(logic [3:0] cls);
        if (stack_top() == K_FUN)
        begin
            if (cls == C_ARROW || cls == C_WHEN)
                closer_stack[open_count - 1] = K_END;
            else if (cls == C_COMMA || cls == C_RPAR)
                open_count--;
        end
        return open_count == 0 && (cls == C_COMMA || cls == C_RPAR);
    endfunction

    // returns 0 when a push finds the stack full
    function automatic bit track_nesting(logic [3:0] cls, logic [3:0] nx, logic [3:0] ax);
        logic [2:0] top;
        top = stack_top();
        if (cls == C_OTHER || cls == C_VAR)
            return 1'b1;
        if (top != K_NONE && closer_code(cls) == top)
        begin
            open_count--;
            return 1'b1;
        end
        if (opener_code(cls) != K_NONE)
            return push_closer(opener_code(cls));
        if (cls == C_FUN && nx == C_LPAR)
            return push_closer(K_FUN);
        if (cls == C_FUN && nx == C_VAR && ax == C_LPAR)
            return push_closer(K_END);
        return 1'b1;
    endfunction

    function automatic mas_out_t split_token(mas_in_t t);
        mas_out_t   r;
        logic [3:0] st;
        int         num;
        int         len;
        int         cons;
        num  = 0;
        len  = 0;
        cons = 0;
        st   = ST_IGNORED;
        if (t.start_of_call)
        begin
            in_call = 1'b0;
            if (t.token_class != C_LPAR)
                st = ST_NO_CALL;
            else
            begin
                open_count = 0;
                args_done  = 0;
                arg_length = 0;
                token_pos  = 1;
                in_call    = 1'b1;
                st         = ST_OPENED;
            end
        end
        else if (!in_call)
            st = ST_IGNORED;
        else if (token_pos >= MAX_TOKENS)
        begin
            st      = ST_OVERFLOW;
            num     = args_done;
            len     = arg_length;
            in_call = 1'b0;
        end
        else
        begin
            token_pos++;
            if (!at_separator(t.token_class))
            begin
                if (!track_nesting(t.token_class, t.next_class, t.after_next_class))
                begin
                    st      = ST_OVERFLOW;
                    num     = args_done;
                    len     = arg_length;
                    in_call = 1'b0;
                end
                else
                begin
                    arg_length++;
                    st  = ST_IN_ARG;
                    num = args_done;
                    len = arg_length;
                end
            end
            else if (arg_length == 0 && (args_done > 0 || t.token_class == C_COMMA))
            begin
                st      = ST_EMPTY_ARG;
                num     = args_done;
                in_call = 1'b0;
            end
            else if (t.token_class == C_RPAR)
            begin
                st      = ST_CALL_END;
                num     = args_done;
                len     = arg_length;
                cons    = token_pos;
                in_call = 1'b0;
            end
            else if (args_done + 1 >= MAX_ARGS)
            begin
                st      = ST_OVERFLOW;
                num     = args_done;
                len     = arg_length;
                in_call = 1'b0;
            end
            else
            begin
                st  = ST_ARG_END;
                num = args_done;
                len = arg_length;
                args_done++;
                arg_length = 0;
            end
        end
        // last token with the call still open
        if (in_call && t.end_of_input)
        begin
            st      = ST_UNTERM;
            num     = args_done;
            len     = arg_length;
            cons    = 0;
            in_call = 1'b0;
        end
        r.status          = st;
        r.argument_number = NUM_W'(num);
        r.argument_length = LEN_W'(len);
        r.consumed_count  = CONSUMED_W'(cons);
        return r;
    endfunction

    function automatic int field_differs(string field, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mas_out_t want;
        int       errs;
        if (!rst_n)
        begin
            open_count = 0;
            args_done  = 0;
            arg_length = 0;
            token_pos  = 0;
            in_call    = 1'b0;
            predicted_status.delete();
            fail_count    <= 0;
            outstanding   <= 0;
            words_checked <= 0;
            status_seen   <= '0;
        end
        else
        begin
            errs = 0;
            if (pop && !empty)
            begin
                if (predicted_status.size() == 0)
                begin
                    $display("%0t: status word with none expected, expected nothing, actual %h",
                             $time, out_data);
                    errs = 1;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    errs += field_differs("status", 32'(want.status),
                                          32'(out_data.status));
                    errs += field_differs("argument_number", 32'(want.argument_number),
                                          32'(out_data.argument_number));
                    errs += field_differs("argument_length", 32'(want.argument_length),
                                          32'(out_data.argument_length));
                    errs += field_differs("consumed_count", 32'(want.consumed_count),
                                          32'(out_data.consumed_count));
                end
                words_checked <= words_checked + 1;
                status_seen[out_data.status] <= 1'b1;
            end
            if (push && !full)
                predicted_status.insert(predicted_status.size(), split_token(in_data));
            fail_count  <= fail_count + errs;
            outstanding <= predicted_status.size();
        end
    end

endmodule

@@ verif/macro_argument_splitter_tb.sv @@
// ----------------------------------------------------------------------------
// macro_argument_splitter_tb
// drives token words into the splitter: a directed set of corner cases,
// a call past the argument limit, then random calls (well formed,
// cut short, deeply nested) mixed with noise, under random idling on both
// sides; the checker predicts and compares every status word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module macro_argument_splitter_tb;

    import mas_pkg::*;

    localparam int RANDOM_TOKENS = 750;
    localparam int HOLD_AFTER    = 150;
    localparam int PAUSE_AT      = 400;
    localparam int CALM_AT       = 620;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 10;

    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     push     = 1'b0;
    mas_in_t  in_data  = '0;
    logic     pop      = 1'b0;
    logic     full;
    logic     empty;
    mas_out_t out_data;

    logic     hold_req  = 1'b0;
    logic     hold_done = 1'b0;
    logic     calm      = 1'b0;
    int       pop_hold  = 0;
    int       stall_cycles = 0;

    int          fail_count;
    int          outstanding;
    int          words_checked;
    logic [15:0] status_seen;

    mas_in_t  token_q [$];
    mas_in_t  seg [$];
    int       tokens_sent = 0;

    macro_argument_splitter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    macro_argument_splitter_checker split_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_data       (in_data),
        .empty         (empty),
        .pop           (pop),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .status_seen   (status_seen)
    );

    always #1 clk = ~clk;

    // result side: short random stalls, one long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold != 0)
        begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if (hold_req && !hold_done)
        begin
            pop       <= 1'b0;
            pop_hold  <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 9);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic add_token(input logic s, input logic [3:0] c);
        mas_in_t t;
        t = '0;
        t.start_of_call = s;
        t.token_class   = c;
        seg.insert(seg.size(), t);
    endtask

    task automatic add_plain();
        add_token(1'b0, $urandom_range(0, 1) ? C_VAR : C_OTHER);
    endtask

    // fills lookahead from the following tokens, optionally cuts the call short
    task automatic flush_seg(input bit cut, input bit mark_last, input bit jitter);
        int n;
        n = seg.size();
        if (cut && n > 1)
            n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++)
        begin
            seg[i].next_class       = (i + 1 < n) ? seg[i + 1].token_class : C_OTHER;
            seg[i].after_next_class = (i + 2 < n) ? seg[i + 2].token_class : C_OTHER;
            if (jitter && $urandom_range(0, 29) == 0)
            begin
                seg[i].next_class       = 4'($urandom_range(0, 15));
                seg[i].after_next_class = 4'($urandom_range(0, 15));
            end
        end
        if (n > 0 && mark_last)
            seg[n - 1].end_of_input = 1'b1;
        for (int i = 0; i < n; i++)
            token_q.insert(token_q.size(), seg[i]);
        seg.delete();
    endtask

    function automatic logic [3:0] pick_opener();
        case ($urandom_range(0, 4))
            0:       return C_LPAR;
            1:       return C_LBRK;
            2:       return C_LBRC;
            3:       return C_LBIN;
            default: return C_BLOCK;
        endcase
    endfunction

    function automatic logic [3:0] closer_of(logic [3:0] o);
        case (o)
            C_LPAR:  return C_RPAR;
            C_LBRK:  return C_RBRK;
            C_LBRC:  return C_RBRC;
            C_LBIN:  return C_RBIN;
            default: return C_END;
        endcase
    endfunction

    task automatic gen_fun(input int form);
        add_token(1'b0, C_FUN);
        case (form)
            0:
            begin
                add_token(1'b0, C_LPAR);
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_RPAR);
                add_token(1'b0, C_ARROW);
                add_plain();
                add_token(1'b0, C_END);
            end
            1:
            begin
                add_token(1'b0, C_LPAR);
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_RPAR);
                add_token(1'b0, C_WHEN);
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_ARROW);
                add_plain();
                add_token(1'b0, C_END);
            end
            2:
            begin
                // named fun opens its own end
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_LPAR);
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_RPAR);
                add_token(1'b0, C_ARROW);
                add_plain();
                add_token(1'b0, C_END);
            end
            3:
                add_token(1'b0, C_OTHER);
            4:
            begin
                // second fun meets the sentinel and pops it
                add_token(1'b0, C_LPAR);
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_RPAR);
                add_token(1'b0, C_FUN);
            end
            5:
            begin
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_OTHER);
            end
            default:
            begin
                // sentinel stays on top until the next comma or ")"
                add_token(1'b0, C_LPAR);
                add_token(1'b0, C_VAR);
                add_token(1'b0, C_RPAR);
            end
        endcase
    endtask

    task automatic gen_argument();
        logic [3:0] closers [$];
        logic [3:0] o;
        int         n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                4:
                begin
                    o = pick_opener();
                    add_token(1'b0, o);
                    closers.insert(closers.size(), closer_of(o));
                end
                5:
                begin
                    if (closers.size() != 0)
                    begin
                        add_token(1'b0, closers[$]);
                        closers.delete(closers.size() - 1);
                    end
                    else
                        add_plain();
                end
                6:
                begin
                    // comma inside brackets is part of the argument
                    if (closers.size() != 0)
                        add_token(1'b0, C_COMMA);
                    else
                        add_plain();
                end
                7:
                    gen_fun($urandom_range(0, 5));
                8:
                    add_token(1'b0, $urandom_range(0, 1) ? C_ARROW : C_WHEN);
                default:
                    add_plain();
            endcase
        end
        while (closers.size() != 0)
        begin
            add_token(1'b0, closers[$]);
            closers.delete(closers.size() - 1);
        end
        if ($urandom_range(0, 5) == 0)
            gen_fun(6);
    endtask

    task automatic gen_call();
        int nargs;
        nargs = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
        add_token(1'b1, C_LPAR);
        for (int i = 0; i < nargs; i++)
        begin
            if ($urandom_range(0, 24) != 0)
                gen_argument();
            if (i < nargs - 1)
                add_token(1'b0, C_COMMA);
        end
        add_token(1'b0, C_RPAR);
    endtask

    task automatic gen_deep();
        logic [3:0] closers [$];
        logic [3:0] o;
        add_token(1'b1, C_LPAR);
        repeat ($urandom_range(24, 34))
        begin
            o = pick_opener();
            add_token(1'b0, o);
            closers.insert(closers.size(), closer_of(o));
            if ($urandom_range(0, 3) == 0)
                add_plain();
        end
        while (closers.size() != 0)
        begin
            add_token(1'b0, closers[$]);
            closers.delete(closers.size() - 1);
        end
        add_token(1'b0, C_RPAR);
    endtask

    task automatic gen_noise();
        mas_in_t t;
        repeat ($urandom_range(1, 8))
        begin
            t.start_of_call    = ($urandom_range(0, 3) == 0);
            t.token_class      = 4'($urandom_range(0, 15));
            t.next_class       = 4'($urandom_range(0, 15));
            t.after_next_class = 4'($urandom_range(0, 15));
            t.end_of_input     = ($urandom_range(0, 7) == 0);
            token_q.insert(token_q.size(), t);
        end
    endtask

    task automatic gen_many_args(input int commas, input bit close);
        add_token(1'b1, C_LPAR);
        repeat (commas)
        begin
            add_plain();
            add_token(1'b0, C_COMMA);
        end
        if (close)
        begin
            add_plain();
            add_token(1'b0, C_RPAR);
        end
        flush_seg(1'b0, 1'b0, 1'b0);
    endtask

    task automatic send_token(input mas_in_t t, input bit gaps);
        if (gaps && !calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        push    <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic send_all();
        bit gaps;
        gaps = ($urandom_range(0, 2) != 0);
        while (token_q.size() != 0)
        begin
            send_token(token_q.pop_front(), gaps);
            tokens_sent++;
        end
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int kind;
        int counted;
        bit paused;
        counted = 0;
        paused  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // start token that is not "("
        add_token(1'b1, C_VAR);
        flush_seg(1'b0, 1'b0, 1'b0);
        // zero-argument call on the last token, then a token while idle
        add_token(1'b1, C_LPAR);
        add_token(1'b0, C_RPAR);
        flush_seg(1'b0, 1'b1, 1'b0);
        add_token(1'b0, C_OTHER);
        flush_seg(1'b0, 1'b0, 1'b0);
        // lone "(" as the last token
        add_token(1'b1, C_LPAR);
        flush_seg(1'b0, 1'b1, 1'b0);
        // empty argument between two commas
        add_token(1'b1, C_LPAR);
        add_token(1'b0, C_VAR);
        add_token(1'b0, C_COMMA);
        add_token(1'b0, C_COMMA);
        // restart while a call is open, then a leading comma
        add_token(1'b1, C_LPAR);
        add_token(1'b0, C_VAR);
        add_token(1'b1, C_LPAR);
        add_token(1'b0, C_COMMA);
        // empty argument before ")"
        add_token(1'b1, C_LPAR);
        add_token(1'b0, C_OTHER);
        add_token(1'b0, C_COMMA);
        add_token(1'b0, C_RPAR);
        // fun token matching the sentinel
        add_token(1'b1, C_LPAR);
        add_token(1'b0, C_FUN);
        add_token(1'b0, C_LPAR);
        add_token(1'b0, C_VAR);
        add_token(1'b0, C_RPAR);
        add_token(1'b0, C_FUN);
        add_token(1'b0, C_RPAR);
        flush_seg(1'b0, 1'b0, 1'b0);
        send_all();
        wait_for_results();

        // argument limit
        gen_many_args(256, 1'b0);
        send_all();

        while (counted < RANDOM_TOKENS)
        begin
            if (counted >= HOLD_AFTER)
                hold_req <= 1'b1;
            if (counted >= PAUSE_AT && !paused)
            begin
                paused = 1'b1;
                wait_for_results();
            end
            if (counted >= CALM_AT)
                calm <= 1'b1;
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3, 4, 5:
                begin
                    gen_call();
                    flush_seg(1'b0, $urandom_range(0, 3) == 0, 1'b1);
                end
                6:
                begin
                    gen_call();
                    flush_seg(1'b1, 1'($urandom_range(0, 1)), 1'b1);
                end
                7:
                begin
                    gen_deep();
                    flush_seg(1'b0, 1'($urandom_range(0, 1)), 1'b1);
                end
                default:
                    gen_noise();
            endcase
            if (kind < 8)
                counted += token_q.size();
            send_all();
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("summary: %0d token words pushed, %0d status words checked",
                 tokens_sent, words_checked);
        $display("summary: status codes seen, one bit per code from 8 down to 0: %b",
                 status_seen[8:0]);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mas_pkg.sv
rtl/core/mas_queue.sv
rtl/core/mas_front.sv
rtl/core/mas_back.sv
rtl/core/macro_argument_splitter.sv
verif/macro_argument_splitter_checker.sv
verif/macro_argument_splitter_tb.sv
